FILE: rtl/rgb2hsl_pkg.sv
// Package for the RGB to HSL converter: field widths, pipeline sizing and the
// record that the front stage hands to the rest of the pipeline.
// Depends on nothing; every other file of the block imports it.
package rgb2hsl_pkg;

   // Widths of the pixel channels and of the result fields.
   localparam int CHAN_WIDTH = 8;
   localparam int OUT_WIDTH  = 16;

   // max + min needs one bit more than a channel.
   localparam int SUM_WIDTH = CHAN_WIDTH + 1;

   // The hue divisor is 6*d, at most 6*255 = 1530, so it needs 11 bits.
   localparam int HUE_DEN_WIDTH = 11;

   // The saturation divisor is 2*(sum or 510-sum), at most 510, so 9 bits.
   localparam int SAT_DEN_WIDTH = 9;

   // Long division layout: stages times quotient bits per stage = 16 bits.
   localparam int DIV_STAGES      = 4;
   localparam int STEPS_PER_STAGE = 4;

   // Front stage, the divider stages, then the output register.
   localparam int LATENCY = DIV_STAGES + 2;

   // One pixel after the front stage.
   typedef struct packed {
      logic                     gray;
      logic [SUM_WIDTH-1:0]     sum;
      logic [HUE_DEN_WIDTH-1:0] hue_num;
      logic [HUE_DEN_WIDTH-1:0] hue_den;
      logic [SAT_DEN_WIDTH-1:0] sat_num;
      logic [SAT_DEN_WIDTH-1:0] sat_den;
   } prep_type;

endpackage

FILE: rtl/rgb2hsl_prep.sv
// Front stage of the RGB to HSL converter: finds max and min, and builds the
// numerators and divisors of hue and saturation. Uses rgb2hsl_pkg.
module rgb2hsl_prep
   import rgb2hsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [CHAN_WIDTH-1:0] red,
   input  logic [CHAN_WIDTH-1:0] green,
   input  logic [CHAN_WIDTH-1:0] blue,
   output logic                  out_valid,
   output prep_type              out_data
);

   logic                     valid_ff;
   prep_type                 data_ff;
   prep_type                 data_in;

   logic [CHAN_WIDTH-1:0]    mx;
   logic [CHAN_WIDTH-1:0]    mn;
   logic [CHAN_WIDTH-1:0]    d;
   logic [HUE_DEN_WIDTH-1:0] d_ext;
   logic [SUM_WIDTH-1:0]     sum;
   logic [CHAN_WIDTH-1:0]    half_den;

   always_comb begin
      // Red wins ties for the maximum, then green.
      if (red >= green && red >= blue) begin
         mx = red;
      end else if (green >= blue) begin
         mx = green;
      end else begin
         mx = blue;
      end
      if (red <= green && red <= blue) begin
         mn = red;
      end else if (green <= blue) begin
         mn = green;
      end else begin
         mn = blue;
      end

      d     = mx - mn;
      d_ext = HUE_DEN_WIDTH'(d);
      sum   = SUM_WIDTH'(mx) + SUM_WIDTH'(mn);

      data_in.gray    = (d == '0);
      data_in.sum     = sum;
      data_in.hue_den = (d_ext << 2) + (d_ext << 1);

      // Hue numerator is sector offset times d plus the signed difference;
      // it always lands in [0, 6d), so modular arithmetic is safe here.
      if (mx == red) begin
         if (green < blue) begin
            data_in.hue_num = data_in.hue_den
                              - (HUE_DEN_WIDTH'(blue) - HUE_DEN_WIDTH'(green));
         end else begin
            data_in.hue_num = HUE_DEN_WIDTH'(green) - HUE_DEN_WIDTH'(blue);
         end
      end else if (mx == green) begin
         data_in.hue_num = (d_ext << 1) + HUE_DEN_WIDTH'(blue) - HUE_DEN_WIDTH'(red);
      end else begin
         data_in.hue_num = (d_ext << 2) + HUE_DEN_WIDTH'(red) - HUE_DEN_WIDTH'(green);
      end

      // d/den equals d*2/(2*den); doubling the divisor keeps d below it.
      if (sum <= SUM_WIDTH'(255)) begin
         half_den = sum[CHAN_WIDTH-1:0];
      end else begin
         half_den = CHAN_WIDTH'(SUM_WIDTH'(510) - sum);
      end
      data_in.sat_den = {half_den, 1'b0};
      data_in.sat_num = SAT_DEN_WIDTH'(d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/rgb2hsl_divider.sv
// Pipelined restoring divider for the RGB to HSL converter: gives
// floor(num * 2^QUO_WIDTH / den) for num < den. Uses rgb2hsl_pkg only for style.
module rgb2hsl_divider
   import rgb2hsl_pkg::*;
#(
   parameter int DEN_WIDTH = 11,
   parameter int STAGES    = 4,
   parameter int STEPS     = 4
) (
   input  logic                        clock,
   input  logic [DEN_WIDTH-1:0]        num,
   input  logic [DEN_WIDTH-1:0]        den,
   output logic [STAGES*STEPS-1:0]     quo
);

   localparam int QUO_WIDTH = STAGES * STEPS;

   logic [DEN_WIDTH-1:0] rem_ff [STAGES-1];
   logic [DEN_WIDTH-1:0] den_ff [STAGES-1];
   logic [QUO_WIDTH-1:0] quo_ff [STAGES];

   logic [DEN_WIDTH-1:0] rem_in [STAGES];
   logic [QUO_WIDTH-1:0] quo_in [STAGES];
   logic [DEN_WIDTH-1:0] den_src [STAGES];

   // Each stage produces STEPS quotient bits, one shift and compare apiece.
   always_comb begin
      logic [DEN_WIDTH:0]   twice;
      logic [DEN_WIDTH-1:0] rem;
      logic [QUO_WIDTH-1:0] q;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            rem        = num;
            q          = '0;
            den_src[s] = den;
         end else begin
            rem        = rem_ff[s-1];
            q          = quo_ff[s-1];
            den_src[s] = den_ff[s-1];
         end
         for (int k = 0; k < STEPS; k++) begin
            twice = {rem, 1'b0};
            if (twice >= {1'b0, den_src[s]}) begin
               rem = DEN_WIDTH'(twice - {1'b0, den_src[s]});
               q   = {q[QUO_WIDTH-2:0], 1'b1};
            end else begin
               rem = twice[DEN_WIDTH-1:0];
               q   = {q[QUO_WIDTH-2:0], 1'b0};
            end
         end
         rem_in[s] = rem;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         quo_ff[s] <= quo_in[s];
      end
      for (int s = 0; s < STAGES - 1; s++) begin
         rem_ff[s] <= rem_in[s];
         den_ff[s] <= den_src[s];
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
// Top level of the RGB to HSL converter: front stage, two pipelined dividers,
// lightness by constant division and the result register.
// Depends on rgb2hsl_pkg, rgb2hsl_prep and rgb2hsl_divider.
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   -------------------------
//   request   req_red, req_green, req_blue           beat when start && !busy
//   response  rsp_hue, rsp_saturation, rsp_lightness beat on rsp_strobe, 1 cycle
//
// One pixel is taken every clock cycle while busy is low; busy is high only during reset.
// Each beat gives one result after one front stage, four divider stages of
// four quotient bits each, and the result register.
// The 16-step long division sets the depth; throughput is one per cycle outside reset.
// Reset (synchronous, active high) drops every beat in flight.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module rgb_to_hsl_converter
   import rgb2hsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CHAN_WIDTH-1:0] req_red,
   input  logic [CHAN_WIDTH-1:0] req_green,
   input  logic [CHAN_WIDTH-1:0] req_blue,
   output logic                  rsp_strobe,
   output logic [OUT_WIDTH-1:0]  rsp_hue,
   output logic [OUT_WIDTH-1:0]  rsp_saturation,
   output logic [OUT_WIDTH-1:0]  rsp_lightness
);

   // One spare bit on top of 64*sum keeps the rounding sum from wrapping
   // for a white pixel, where 64*510 + 127 + 1 reaches 2^15.
   localparam int SCALED_WIDTH = SUM_WIDTH + 7;

   logic                     accept;
   logic                     prep_valid;
   prep_type                 prep_data;

   logic [OUT_WIDTH-1:0]     hue_quo;
   logic [OUT_WIDTH-1:0]     sat_quo;

   // Side band that rides along with the divider stages.
   logic                     valid_ff [DIV_STAGES];
   logic                     gray_ff  [DIV_STAGES];
   logic [OUT_WIDTH-1:0]     light_ff [DIV_STAGES];

   logic [SCALED_WIDTH-1:0]  scaled;
   logic [CHAN_WIDTH-1:0]    scaled_div;
   logic [OUT_WIDTH-1:0]     light_in;

   logic                     strobe_ff;
   logic [OUT_WIDTH-1:0]     hue_ff;
   logic [OUT_WIDTH-1:0]     sat_ff;
   logic [OUT_WIDTH-1:0]     lightness_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   rgb2hsl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (prep_valid),
      .out_data  (prep_data)
   );

   // Hue: (off*d + diff) * 65536 / (6d).
   rgb2hsl_divider #(
      .DEN_WIDTH (HUE_DEN_WIDTH),
      .STAGES    (DIV_STAGES),
      .STEPS     (STEPS_PER_STAGE)
   ) u_hue_div (
      .clock (clock),
      .num   (prep_data.hue_num),
      .den   (prep_data.hue_den),
      .quo   (hue_quo)
   );

   // Saturation: d * 65536 / (2*den), which equals d * 32768 / den.
   rgb2hsl_divider #(
      .DEN_WIDTH (SAT_DEN_WIDTH),
      .STAGES    (DIV_STAGES),
      .STEPS     (STEPS_PER_STAGE)
   ) u_sat_div (
      .clock (clock),
      .num   (prep_data.sat_num),
      .den   (prep_data.sat_den),
      .quo   (sat_quo)
   );

   // Lightness is sum * 32768 / 510 = 64*sum + (64*sum)/255. The division by
   // 255 uses (x + (x >> 8) + 1) >> 8, which is exact for x below 65535.
   always_comb begin
      scaled     = {1'b0, prep_data.sum, 6'b0};
      scaled_div = CHAN_WIDTH'((scaled + (scaled >> 8) + SCALED_WIDTH'(1)) >> 8);
      light_in   = OUT_WIDTH'(scaled) + OUT_WIDTH'(scaled_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         valid_ff[0] <= prep_valid;
         for (int s = 1; s < DIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         strobe_ff <= valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      gray_ff[0]  <= prep_data.gray;
      light_ff[0] <= light_in;
      for (int s = 1; s < DIV_STAGES; s++) begin
         gray_ff[s]  <= gray_ff[s-1];
         light_ff[s] <= light_ff[s-1];
      end
      // A gray pixel divides by zero; its hue and saturation are defined as 0.
      hue_ff       <= gray_ff[DIV_STAGES-1] ? '0 : hue_quo;
      sat_ff       <= gray_ff[DIV_STAGES-1] ? '0 : sat_quo;
      lightness_ff <= light_ff[DIV_STAGES-1];
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = lightness_ff;

   // Every result beat comes from a request beat a fixed number of cycles back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result beat without a matching request beat");

   // Saturation and lightness never pass 1.0 in Q1.15.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_saturation <= OUT_WIDTH'(32768))
                     && (rsp_lightness <= OUT_WIDTH'(32768)))
      else $error("saturation or lightness above 1.0");

   // Zero saturation only comes from a gray pixel, whose hue must be zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("gray pixel with nonzero hue");

endmodule
